// ===== src/jeo_pkg.sv =====
// Shared constants and controller/datapath interface types for the Josephus elimination block.
package jeo_pkg;

  localparam int MAX_PEOPLE = 64;
  localparam int IDX_W = $clog2(MAX_PEOPLE);
  localparam int CNT_W = $clog2(MAX_PEOPLE + 1);

  localparam int COUNT_W = 7;
  localparam int STEP_W = 8;
  localparam int PERSON_W = 7;
  localparam int S_TDATA_W = 16;
  localparam int M_TDATA_W = 8;

  typedef struct packed {
    logic load;
    logic init_wr;
    logic rd_pos;
    logic hop_step;
    logic hop_end;
    logic unlink;
    logic emit_surv;
  } cmd_t;

  typedef struct packed {
    logic n_is_one;
    logic init_done;
    logic hop_zero;
    logic left_gt2;
    logic out_free;
  } sts_t;

endpackage

// ===== src/josephus_elimination_order.sv =====
// Top level of the Josephus elimination order block.
// A request of n people and step k first builds the table, then walks the ring for each
// removal, then emits the survivor. The walk is paced by the single successor table read
// port, one pointer hop per cycle.
// One request is worked at a time; the next is accepted once the survivor is registered.
// Reset clears the controller and the output valid; the successor table is not cleared.
module josephus_elimination_order (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // Fields from bit 0: people_count[6:0], step_size[14:7], zero pad[15].
  input  logic [jeo_pkg::S_TDATA_W-1:0]   s_tdata,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // Fields from bit 0: removed_person[6:0], zero pad[7].
  output logic [jeo_pkg::M_TDATA_W-1:0]   m_tdata,
  output logic                            m_tlast
);

  jeo_pkg::cmd_t                 cmd;
  jeo_pkg::sts_t                 sts;
  logic [jeo_pkg::PERSON_W-1:0]  out_person;

  jeo_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  jeo_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .people_count (s_tdata[jeo_pkg::COUNT_W-1:0]),
    .step_size    (s_tdata[jeo_pkg::COUNT_W +: jeo_pkg::STEP_W]),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .out_person   (out_person),
    .out_last     (m_tlast)
  );

  assign m_tdata = jeo_pkg::M_TDATA_W'(out_person);

endmodule

// ===== src/jeo_datapath.sv =====
// Datapath: successor table, walker registers and the output word register.
module jeo_datapath (
  input  logic                           clk,
  input  logic                           rst,
  input  jeo_pkg::cmd_t                  cmd,
  output jeo_pkg::sts_t                  sts,
  input  logic [jeo_pkg::COUNT_W-1:0]    people_count,
  input  logic [jeo_pkg::STEP_W-1:0]     step_size,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [jeo_pkg::PERSON_W-1:0]   out_person,
  output logic                           out_last
);

  logic [jeo_pkg::IDX_W-1:0]  mem [jeo_pkg::MAX_PEOPLE];
  logic [jeo_pkg::IDX_W-1:0]  rd_data;
  logic [jeo_pkg::IDX_W-1:0]  rd_addr;
  logic                       rd_en;
  logic                       wr_en;
  logic [jeo_pkg::IDX_W-1:0]  wr_addr;
  logic [jeo_pkg::IDX_W-1:0]  wr_data;

  logic [jeo_pkg::IDX_W-1:0]  pos;
  logic [jeo_pkg::IDX_W-1:0]  last_idx;
  logic [jeo_pkg::IDX_W-1:0]  init_idx;
  logic [jeo_pkg::IDX_W-1:0]  victim;
  logic [jeo_pkg::CNT_W-1:0]  left;
  logic [jeo_pkg::STEP_W-1:0] step_hops;
  logic [jeo_pkg::STEP_W-1:0] hop_cnt;

  logic [jeo_pkg::CNT_W-1:0]  n_load;
  logic [jeo_pkg::STEP_W-1:0] hops_load;

  always_comb begin
    if (people_count == '0) begin
      n_load = jeo_pkg::CNT_W'(1);
    end else if (32'(people_count) > 32'(jeo_pkg::MAX_PEOPLE)) begin
      n_load = jeo_pkg::CNT_W'(jeo_pkg::MAX_PEOPLE);
    end else begin
      n_load = jeo_pkg::CNT_W'(people_count);
    end
    hops_load = (step_size == '0) ? '0 : step_size - jeo_pkg::STEP_W'(1);
  end

  always_comb begin
    rd_en   = cmd.rd_pos | cmd.hop_step | cmd.hop_end;
    rd_addr = cmd.rd_pos ? pos : rd_data;
    wr_en   = cmd.init_wr | cmd.unlink;
    if (cmd.init_wr) begin
      wr_addr = init_idx;
      wr_data = (init_idx == last_idx) ? '0 : init_idx + jeo_pkg::IDX_W'(1);
    end else begin
      wr_addr = pos;
      wr_data = rd_data;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      last_idx  <= jeo_pkg::IDX_W'(n_load - jeo_pkg::CNT_W'(1));
      pos       <= jeo_pkg::IDX_W'(n_load - jeo_pkg::CNT_W'(1));
      left      <= n_load;
      init_idx  <= '0;
      step_hops <= hops_load;
    end
    if (cmd.init_wr) begin
      init_idx <= init_idx + jeo_pkg::IDX_W'(1);
    end
    if (cmd.rd_pos) begin
      hop_cnt <= step_hops;
    end
    if (cmd.hop_step) begin
      pos     <= rd_data;
      hop_cnt <= hop_cnt - jeo_pkg::STEP_W'(1);
    end
    if (cmd.hop_end) begin
      victim <= rd_data;
    end
    if (cmd.unlink) begin
      left <= left - jeo_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.unlink || cmd.emit_surv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.unlink) begin
      out_person <= jeo_pkg::PERSON_W'({1'b0, victim} + (jeo_pkg::IDX_W + 1)'(1));
      out_last   <= 1'b0;
    end else if (cmd.emit_surv) begin
      out_person <= jeo_pkg::PERSON_W'({1'b0, pos} + (jeo_pkg::IDX_W + 1)'(1));
      out_last   <= 1'b1;
    end
  end

  always_comb begin
    sts.n_is_one  = (last_idx == '0);
    sts.init_done = (init_idx == last_idx);
    sts.hop_zero  = (hop_cnt == '0);
    sts.left_gt2  = (left > jeo_pkg::CNT_W'(2));
    sts.out_free  = ~out_valid | out_ready;
  end

endmodule

// ===== src/jeo_controller.sv =====
// Controller state machine that sequences table build, walking and result emission.
module jeo_controller (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  jeo_pkg::sts_t sts,
  output jeo_pkg::cmd_t cmd
);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_INIT = 6'b000010,
    ST_READ = 6'b000100,
    ST_HOP  = 6'b001000,
    ST_EMIT = 6'b010000,
    ST_SURV = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_INIT;
        end
      end
      ST_INIT: begin
        cmd.init_wr = 1'b1;
        if (sts.init_done) begin
          state_next = sts.n_is_one ? ST_SURV : ST_READ;
        end
      end
      ST_READ: begin
        cmd.rd_pos = 1'b1;
        state_next = ST_HOP;
      end
      ST_HOP: begin
        if (sts.hop_zero) begin
          cmd.hop_end = 1'b1;
          state_next  = ST_EMIT;
        end else begin
          cmd.hop_step = 1'b1;
        end
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.unlink = 1'b1;
          state_next = sts.left_gt2 ? ST_READ : ST_SURV;
        end
      end
      ST_SURV: begin
        if (sts.out_free) begin
          cmd.emit_surv = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule
